@@ rtl/sdepq_pkg.sv @@
// sdepq_pkg: sizes, command and status codes and the controller/datapath
// command and status types of the sorted double-ended priority queue
// no dependencies
package sdepq_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_BITS  = 16;
	localparam int TAG_BITS  = 16;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int IDX_BITS  = $clog2(DEPTH);

	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_POP_MIN = 2'd1;
	localparam logic [1:0] CMD_POP_MAX = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic capture;
		logic push;
		logic pop_min;
		logic pop_max;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

@@ rtl/sdepq_ctrl.sv @@
// sdepq_ctrl: command decode, handshake and status state machine
// depends on sdepq_pkg
module sdepq_ctrl
	import sdepq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       done,
	output logic       pop_valid,
	output logic [1:0] status
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_REPORT = 1'b1;

	logic       state_q;
	logic       accept;
	logic       is_pop;
	logic       pop_valid_q;
	logic [1:0] status_q;

	assign accept = start && (state_q == S_IDLE);
	assign is_pop = (command == CMD_POP_MIN) || (command == CMD_POP_MAX);

	always_comb begin
		cmd.capture = accept;
		cmd.push    = accept && (command == CMD_PUSH) && !stat.full;
		cmd.pop_min = accept && (command == CMD_POP_MIN) && !stat.empty;
		cmd.pop_max = accept && (command == CMD_POP_MAX) && !stat.empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pop_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q     <= S_REPORT;
						pop_valid_q <= is_pop && !stat.empty;
						if ((command == CMD_PUSH) && stat.full) begin
							status_q <= ST_FULL;
						end else if (is_pop && stat.empty) begin
							status_q <= ST_EMPTY;
						end else begin
							status_q <= ST_OK;
						end
					end
				end
				S_REPORT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q == S_REPORT);
	assign done      = (state_q == S_REPORT);
	assign pop_valid = pop_valid_q;
	assign status    = status_q;

endmodule

@@ rtl/sdepq_datapath.sv @@
// sdepq_datapath: sorted shift array of keys and tags with per-slot compare,
// entry count and popped entry registers
// depends on sdepq_pkg
module sdepq_datapath
	import sdepq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic [KEY_BITS-1:0] key,
	input  logic [TAG_BITS-1:0] tag,
	output dp_stat_t            stat,
	output logic [KEY_BITS-1:0] popped_key,
	output logic [TAG_BITS-1:0] popped_tag,
	output logic [KEY_BITS-1:0] min_key,
	output logic [KEY_BITS-1:0] max_key,
	output logic [CNT_BITS-1:0] entry_count,
	output logic                is_empty
);

	logic [KEY_BITS-1:0] keys_q [DEPTH];
	logic [TAG_BITS-1:0] tags_q [DEPTH];
	logic [CNT_BITS-1:0] count_q;
	logic [KEY_BITS-1:0] popped_key_q;
	logic [TAG_BITS-1:0] popped_tag_q;

	logic [DEPTH-1:0]    gt;
	logic [DEPTH-1:0]    gt_prev;
	logic [IDX_BITS-1:0] last_idx;
	logic                empty;

	assign empty    = (count_q == '0);
	assign last_idx = IDX_BITS'(count_q - CNT_BITS'(1));

	// slot holds a smaller key than the incoming one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CNT_BITS'(i) < count_q) && (key > keys_q[i]);
		end
		gt_prev[0] = 1'b1;
		for (int i = 1; i < DEPTH; i++) begin
			gt_prev[i] = gt[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (!gt[i] && gt_prev[i]) begin
					keys_q[i] <= key;
					tags_q[i] <= tag;
				end
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (!gt[i] && !gt_prev[i]) begin
					keys_q[i] <= keys_q[i-1];
					tags_q[i] <= tags_q[i-1];
				end
			end
		end else if (cmd.pop_min) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				keys_q[i] <= keys_q[i+1];
				tags_q[i] <= tags_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			if (cmd.pop_min) begin
				popped_key_q <= keys_q[0];
				popped_tag_q <= tags_q[0];
			end else if (cmd.pop_max) begin
				popped_key_q <= keys_q[last_idx];
				popped_tag_q <= tags_q[last_idx];
			end else begin
				popped_key_q <= '0;
				popped_tag_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CNT_BITS'(1);
		end else if (cmd.pop_min || cmd.pop_max) begin
			count_q <= count_q - CNT_BITS'(1);
		end
	end

	assign stat.full  = (count_q == CNT_BITS'(DEPTH));
	assign stat.empty = empty;

	assign popped_key  = popped_key_q;
	assign popped_tag  = popped_tag_q;
	assign min_key     = empty ? '0 : keys_q[0];
	assign max_key     = empty ? '0 : keys_q[last_idx];
	assign entry_count = count_q;
	assign is_empty    = empty;

endmodule

@@ rtl/sorted_double_ended_priority_queue_top.sv @@
// sorted_double_ended_priority_queue_top: top level joining controller and datapath
// depends on sdepq_pkg, sdepq_ctrl, sdepq_datapath
//
// In each operation the beat is taken when start is high and busy low, the
// sorted slot array compares every slot with the new key and, on a push or
// a minimum pop, shifts at that same edge, and in the next cycle done pulses
// for one cycle with the popped entry, the new minimum, maximum and count,
// and the status. busy is high during that result cycle, so no beat is taken
// then. The outputs hold until the next beat, but done marks the result only
// once and cannot be held off; a receiver must take it in that cycle.
module sorted_double_ended_priority_queue_top
	import sdepq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          command,
	input  logic [KEY_BITS-1:0] key,
	input  logic [TAG_BITS-1:0] tag,
	output logic                done,
	output logic                pop_valid,
	output logic [KEY_BITS-1:0] popped_key,
	output logic [TAG_BITS-1:0] popped_tag,
	output logic [KEY_BITS-1:0] min_key,
	output logic [KEY_BITS-1:0] max_key,
	output logic [CNT_BITS-1:0] entry_count,
	output logic                is_empty,
	output logic [1:0]          status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sdepq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (command),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.pop_valid (pop_valid),
		.status    (status)
	);

	sdepq_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.key         (key),
		.tag         (tag),
		.stat        (stat),
		.popped_key  (popped_key),
		.popped_tag  (popped_tag),
		.min_key     (min_key),
		.max_key     (max_key),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

endmodule

@@ rtl/sdepq_checker.sv @@
// sdepq_checker: port-level assertions on the queue top level, bound to it
// depends on sdepq_pkg and sorted_double_ended_priority_queue_top
module sdepq_checker
	import sdepq_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic                pop_valid,
	input logic [KEY_BITS-1:0] popped_key,
	input logic [KEY_BITS-1:0] min_key,
	input logic [KEY_BITS-1:0] max_key,
	input logic [CNT_BITS-1:0] entry_count,
	input logic                is_empty,
	input logic [1:0]          status
);

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("accepted beat without result");

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_empty |-> (entry_count == '0) && (min_key == '0) && (max_key == '0))
		else $error("empty queue reports entries");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && !is_empty |-> (min_key <= max_key) && (entry_count <= CNT_BITS'(DEPTH)))
		else $error("minimum above maximum or count out of range");

	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pop_valid || (popped_key == '0)) && (!pop_valid || (status == ST_OK)))
		else $error("popped key without a pop");

endmodule

bind sorted_double_ended_priority_queue_top sdepq_checker u_sdepq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.pop_valid   (pop_valid),
	.popped_key  (popped_key),
	.min_key     (min_key),
	.max_key     (max_key),
	.entry_count (entry_count),
	.is_empty    (is_empty),
	.status      (status)
);
